// ===== hw/rtl/fpsc_pkg.sv =====
// Shared constants, tables and stage counts for the fixed-point sine and cosine pipeline.
`timescale 1ns / 1ps
`default_nettype none

package fpsc_pkg;

    // Pipeline depth of each section
    localparam int REDUCE_STAGES = 5;
    localparam int SERIES_STAGES = 8;
    localparam int TOTAL_STAGES  = REDUCE_STAGES + SERIES_STAGES;

    // One full turn in tenths of a degree
    localparam longint unsigned TURN_TENTHS = 64'd3600;

    // Multiple of a turn that lifts any 32-bit signed angle to a non-negative value
    localparam logic [32:0] TURN_OFFSET = 33'd2147486400;

    // Quadrant boundaries of a reduced angle
    localparam logic [11:0] QUARTER_TURN  = 12'd900;
    localparam logic [11:0] HALF_TURN     = 12'd1800;
    localparam logic [11:0] THREE_QUARTER = 12'd2700;
    localparam logic [11:0] FULL_TURN     = 12'd3600;

    // Partial-sum reduction steps (sum of five residues stays below five turns)
    localparam logic [14:0] TURN_X1 = 15'd3600;
    localparam logic [14:0] TURN_X2 = 15'd7200;
    localparam logic [14:0] TURN_X3 = 15'd10800;
    localparam logic [14:0] TURN_X4 = 15'd14400;

    // Residue of each byte of the lifted angle, modulo one turn
    typedef logic [11:0] mod_tbl_t [256];

    function automatic mod_tbl_t build_mod_tbl(input int unsigned byte_pos);
        longint unsigned weight;
        mod_tbl_t        tbl;
        weight = (64'd1 << (8 * byte_pos)) % TURN_TENTHS;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i] = 12'((longint'(i) * weight) % TURN_TENTHS);
        end
        return tbl;
    endfunction

    localparam mod_tbl_t MOD_TBL0 = build_mod_tbl(0);
    localparam mod_tbl_t MOD_TBL1 = build_mod_tbl(1);
    localparam mod_tbl_t MOD_TBL2 = build_mod_tbl(2);
    localparam mod_tbl_t MOD_TBL3 = build_mod_tbl(3);
    localparam logic [11:0] MSB_RESIDUE = 12'((64'd1 << 32) % TURN_TENTHS);

    // Degrees-tenths to Q16 radians: t * 1143819 / 10000
    localparam logic [20:0] SCALE_MUL   = 21'd1143819;
    localparam int          DIV10K_SHIFT = 44;
    localparam logic [30:0] DIV10K_MUL  =
        31'(((64'd1 << DIV10K_SHIFT) + 64'd9999) / 64'd10000);

    // Taylor coefficient dividers as reciprocal multiplies
    localparam int          DIV6_SHIFT = 21;
    localparam logic [18:0] DIV6_MUL   = 19'(((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6);
    localparam int          DIV120_SHIFT = 27;
    localparam logic [20:0] DIV120_MUL   =
        21'(((64'd1 << DIV120_SHIFT) + 64'd119) / 64'd120);
    localparam int          DIV5040_SHIFT = 34;
    localparam logic [21:0] DIV5040_MUL   =
        22'(((64'd1 << DIV5040_SHIFT) + 64'd5039) / 64'd5040);

    localparam logic [16:0] Q16_ONE = 17'd65536;

endpackage

`default_nettype wire

// ===== hw/rtl/fixed_point_sine_cosine.sv =====
// Top level: pipelined fixed-point sine and cosine of an angle in tenths of a degree.
//
// Takes one angle per clock and returns its sine and cosine in signed Q16
// (65536 is one). The angle may span any number of turns. Results leave in
// order, thirteen register stages after the angle is taken: five stages reduce
// the angle to one turn (byte-residue tables, a wrap, the cosine quarter-turn
// offset and the quadrant fold), eight more scale it to radians and evaluate the
// series with at most two multipliers per stage on each lane. Every stage is gated
// on its own, so bubbles close up behind a stalled result and the angle side stalls
// only when every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_sine_cosine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               angle_valid,
    output logic                    angle_stall,
    input  wire logic signed [31:0] angle_tenths,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [17:0]      sine_q16,
    output logic signed [17:0]      cosine_q16
);

    localparam int NSTAGE = fpsc_pkg::TOTAL_STAGES;
    localparam int NRED   = fpsc_pkg::REDUCE_STAGES;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] ready;

    logic [9:0] sin_t;
    logic [9:0] cos_t;
    logic       sin_neg;
    logic       cos_neg;

    // A stage loads when it is empty or its contents move on
    always_comb
    begin
        ready[NSTAGE-1] = ~valid_reg[NSTAGE-1] | ~result_stall;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            ready[i] = ~valid_reg[i] | ready[i+1];
        end
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = (i == 0) ? angle_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    fpsc_reduce u_reduce (
        .clk          (clk),
        .ena          (ready[NRED-1:0]),
        .angle_tenths (angle_tenths),
        .sin_t        (sin_t),
        .sin_neg      (sin_neg),
        .cos_t        (cos_t),
        .cos_neg      (cos_neg)
    );

    fpsc_series u_sine (
        .clk    (clk),
        .ena    (ready[NSTAGE-1:NRED]),
        .t      (sin_t),
        .neg    (sin_neg),
        .result (sine_q16)
    );

    fpsc_series u_cosine (
        .clk    (clk),
        .ena    (ready[NSTAGE-1:NRED]),
        .t      (cos_t),
        .neg    (cos_neg),
        .result (cosine_q16)
    );

    assign angle_stall  = ~ready[0];
    assign result_valid = valid_reg[NSTAGE-1];

endmodule

`default_nettype wire

// ===== hw/rtl/fpsc_reduce.sv =====
// Angle reduction to one turn, cosine offset and first-quadrant fold for both lanes.
`timescale 1ns / 1ps
`default_nettype none

module fpsc_reduce (
    input  wire logic                                  clk,
    input  wire logic [fpsc_pkg::REDUCE_STAGES-1:0]    ena,
    input  wire logic signed [31:0]                    angle_tenths,
    output logic      [9:0]                            sin_t,
    output logic                                       sin_neg,
    output logic      [9:0]                            cos_t,
    output logic                                       cos_neg
);

    logic [32:0] lift_reg;
    logic [32:0] lift_next;
    logic [14:0] psum_reg;
    logic [14:0] psum_next;
    logic [11:0] red_reg;
    logic [11:0] red_next;
    logic [11:0] sin_a_reg;
    logic [11:0] cos_a_reg;
    logic [11:0] cos_a_next;
    logic [9:0]  sin_t_reg;
    logic [9:0]  cos_t_reg;
    logic        sin_neg_reg;
    logic        cos_neg_reg;
    logic [10:0] sin_fold_next;
    logic [10:0] cos_fold_next;

    // Fold into 0..900, return {negate, angle}
    function automatic logic [10:0] fold(input logic [11:0] a);
        logic [11:0] t;
        logic        neg;
        if (a <= fpsc_pkg::QUARTER_TURN)
        begin
            t   = a;
            neg = 1'b0;
        end
        else if (a <= fpsc_pkg::HALF_TURN)
        begin
            t   = fpsc_pkg::HALF_TURN - a;
            neg = 1'b0;
        end
        else if (a <= fpsc_pkg::THREE_QUARTER)
        begin
            t   = a - fpsc_pkg::HALF_TURN;
            neg = 1'b1;
        end
        else
        begin
            t   = fpsc_pkg::FULL_TURN - a;
            neg = 1'b1;
        end
        return {neg, t[9:0]};
    endfunction

    always_comb
    begin
        // Lift by a whole number of turns so the remainder is never negative
        lift_next = {angle_tenths[31], angle_tenths} + fpsc_pkg::TURN_OFFSET;

        psum_next = 15'(fpsc_pkg::MOD_TBL0[lift_reg[7:0]])
                  + 15'(fpsc_pkg::MOD_TBL1[lift_reg[15:8]])
                  + 15'(fpsc_pkg::MOD_TBL2[lift_reg[23:16]])
                  + 15'(fpsc_pkg::MOD_TBL3[lift_reg[31:24]])
                  + (lift_reg[32] ? 15'(fpsc_pkg::MSB_RESIDUE) : 15'd0);

        if (psum_reg >= fpsc_pkg::TURN_X4)
        begin
            red_next = 12'(psum_reg - fpsc_pkg::TURN_X4);
        end
        else if (psum_reg >= fpsc_pkg::TURN_X3)
        begin
            red_next = 12'(psum_reg - fpsc_pkg::TURN_X3);
        end
        else if (psum_reg >= fpsc_pkg::TURN_X2)
        begin
            red_next = 12'(psum_reg - fpsc_pkg::TURN_X2);
        end
        else if (psum_reg >= fpsc_pkg::TURN_X1)
        begin
            red_next = 12'(psum_reg - fpsc_pkg::TURN_X1);
        end
        else
        begin
            red_next = psum_reg[11:0];
        end

        // Cosine angle: add a quarter turn and wrap
        if (red_reg >= fpsc_pkg::THREE_QUARTER)
        begin
            cos_a_next = red_reg - fpsc_pkg::THREE_QUARTER;
        end
        else
        begin
            cos_a_next = red_reg + fpsc_pkg::QUARTER_TURN;
        end

        sin_fold_next = fold(sin_a_reg);
        cos_fold_next = fold(cos_a_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ena[0])
        begin
            lift_reg <= lift_next;
        end
        if (ena[1])
        begin
            psum_reg <= psum_next;
        end
        if (ena[2])
        begin
            red_reg <= red_next;
        end
        if (ena[3])
        begin
            sin_a_reg <= red_reg;
            cos_a_reg <= cos_a_next;
        end
        if (ena[4])
        begin
            sin_neg_reg <= sin_fold_next[10];
            sin_t_reg   <= sin_fold_next[9:0];
            cos_neg_reg <= cos_fold_next[10];
            cos_t_reg   <= cos_fold_next[9:0];
        end
    end

    assign sin_t   = sin_t_reg;
    assign sin_neg = sin_neg_reg;
    assign cos_t   = cos_t_reg;
    assign cos_neg = cos_neg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fpsc_series.sv =====
// One lane: scale to Q16 radians, four-term Taylor series, clamp and sign.
`timescale 1ns / 1ps
`default_nettype none

module fpsc_series (
    input  wire logic                                  clk,
    input  wire logic [fpsc_pkg::SERIES_STAGES-1:0]    ena,
    input  wire logic [9:0]                            t,
    input  wire logic                                  neg,
    output logic signed [17:0]                         result
);

    logic [29:0] scaled_reg;
    logic [16:0] x_reg [1:6];
    logic [17:0] x2_reg [2:4];
    logic [17:0] p3_reg;
    logic [19:0] p5_reg;
    logic [20:0] p7_reg;
    logic [15:0] d3_reg [4:6];
    logic [13:0] d5_reg [5:6];
    logic [8:0]  d7_reg;
    logic        neg_reg [0:6];
    logic signed [17:0] result_reg;

    logic [29:0] scaled_next;
    logic [60:0] div10k_prod;
    logic [33:0] sq_prod;
    logic [34:0] cube_prod;
    logic [35:0] p5_prod;
    logic [36:0] d3_prod;
    logic [37:0] p7_prod;
    logic [40:0] d5_prod;
    logic [42:0] d7_prod;
    logic signed [18:0] sum;
    logic [16:0] mag;
    logic signed [17:0] result_next;

    always_comb
    begin
        scaled_next = 30'(31'(t) * 31'(fpsc_pkg::SCALE_MUL));
        div10k_prod = 61'(scaled_reg) * 61'(fpsc_pkg::DIV10K_MUL);
        sq_prod     = 34'(x_reg[1]) * 34'(x_reg[1]);
        cube_prod   = 35'(x_reg[2]) * 35'(x2_reg[2]);
        p5_prod     = 36'(p3_reg) * 36'(x2_reg[3]);
        d3_prod     = 37'(p3_reg) * 37'(fpsc_pkg::DIV6_MUL);
        p7_prod     = 38'(p5_reg) * 38'(x2_reg[4]);
        d5_prod     = 41'(p5_reg) * 41'(fpsc_pkg::DIV120_MUL);
        d7_prod     = 43'(p7_reg) * 43'(fpsc_pkg::DIV5040_MUL);

        sum = $signed({2'b00, x_reg[6]})
            - $signed({3'b000, d3_reg[6]})
            + $signed({5'b00000, d5_reg[6]})
            - $signed({10'b0000000000, d7_reg});

        // Clamp to 0..one before applying the quadrant sign
        if (sum[18])
        begin
            mag = 17'd0;
        end
        else if (sum[17:0] > {1'b0, fpsc_pkg::Q16_ONE})
        begin
            mag = fpsc_pkg::Q16_ONE;
        end
        else
        begin
            mag = sum[16:0];
        end

        result_next = neg_reg[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (ena[0])
        begin
            scaled_reg <= scaled_next;
            neg_reg[0] <= neg;
        end
        if (ena[1])
        begin
            x_reg[1]   <= div10k_prod[60:44];
            neg_reg[1] <= neg_reg[0];
        end
        if (ena[2])
        begin
            x_reg[2]   <= x_reg[1];
            x2_reg[2]  <= sq_prod[33:16];
            neg_reg[2] <= neg_reg[1];
        end
        if (ena[3])
        begin
            x_reg[3]   <= x_reg[2];
            x2_reg[3]  <= x2_reg[2];
            p3_reg     <= cube_prod[33:16];
            neg_reg[3] <= neg_reg[2];
        end
        if (ena[4])
        begin
            x_reg[4]   <= x_reg[3];
            x2_reg[4]  <= x2_reg[3];
            p5_reg     <= p5_prod[35:16];
            d3_reg[4]  <= d3_prod[36:21];
            neg_reg[4] <= neg_reg[3];
        end
        if (ena[5])
        begin
            x_reg[5]   <= x_reg[4];
            p7_reg     <= p7_prod[36:16];
            d3_reg[5]  <= d3_reg[4];
            d5_reg[5]  <= d5_prod[40:27];
            neg_reg[5] <= neg_reg[4];
        end
        if (ena[6])
        begin
            x_reg[6]   <= x_reg[5];
            d7_reg     <= d7_prod[42:34];
            d5_reg[6]  <= d5_reg[5];
            d3_reg[6]  <= d3_reg[5];
            neg_reg[6] <= neg_reg[5];
        end
        if (ena[7])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
